// ----- sv/bqc_pkg.sv -----
// ----------------------------------------------------------------------------
// bqc_pkg: shared types and constants for the bracket and quote checker
// Beat formats, lexical mode codes, status codes and bracket kind codes.
// ----------------------------------------------------------------------------
package bqc_pkg;

   // Default number of stack entries
   localparam int BQC_STACK_DEPTH = 1024;

   // Input beat: one text byte or an end-of-text marker
   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_type;

   // Result beat
   typedef struct packed {
      logic [3:0] status;
      logic       open_left;
   } rsp_type;

   // Lexical mode codes
   localparam int MODE_W = 4;
   localparam logic [MODE_W-1:0] MODE_NORMAL     = 4'd0;
   localparam logic [MODE_W-1:0] MODE_SLASH      = 4'd1;
   localparam logic [MODE_W-1:0] MODE_DQ         = 4'd2;
   localparam logic [MODE_W-1:0] MODE_DQ_ESC     = 4'd3;
   localparam logic [MODE_W-1:0] MODE_SQ         = 4'd4;
   localparam logic [MODE_W-1:0] MODE_SQ_ESC     = 4'd5;
   localparam logic [MODE_W-1:0] MODE_LINE       = 4'd6;
   localparam logic [MODE_W-1:0] MODE_BLOCK      = 4'd7;
   localparam logic [MODE_W-1:0] MODE_BLOCK_STAR = 4'd8;
   localparam logic [MODE_W-1:0] MODE_HALTED     = 4'd9;

   // Status codes
   localparam logic [3:0] ST_OK          = 4'd0;
   localparam logic [3:0] ST_BAD_PAREN   = 4'd1;
   localparam logic [3:0] ST_BAD_BRACE   = 4'd2;
   localparam logic [3:0] ST_BAD_SQUARE  = 4'd3;
   localparam logic [3:0] ST_OPEN_REMAIN = 4'd4;
   localparam logic [3:0] ST_DQ_ESC_END  = 4'd5;
   localparam logic [3:0] ST_DQ_OPEN     = 4'd6;
   localparam logic [3:0] ST_SQ_ESC_END  = 4'd7;
   localparam logic [3:0] ST_SQ_OPEN     = 4'd8;
   localparam logic [3:0] ST_BLOCK_OPEN  = 4'd9;
   localparam logic [3:0] ST_OVERFLOW    = 4'd10;

   // Bracket kind codes as kept on the stack
   localparam int KIND_W = 2;
   localparam logic [KIND_W-1:0] KIND_PAREN  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_BRACE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SQUARE = 2'd2;

   // Characters of interest
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_LBRACE  = 8'h7B;
   localparam logic [7:0] CH_RBRACE  = 8'h7D;
   localparam logic [7:0] CH_LSQUARE = 8'h5B;
   localparam logic [7:0] CH_RSQUARE = 8'h5D;
   localparam logic [7:0] CH_DQUOTE  = 8'h22;
   localparam logic [7:0] CH_SQUOTE  = 8'h27;
   localparam logic [7:0] CH_BSLASH  = 8'h5C;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;

   // Stack operation requested by the lexer for one beat
   typedef struct packed {
      logic              push;
      logic              pop;
      logic [KIND_W-1:0] kind;
   } stack_op_type;

endpackage

// ----- sv/bqc_ram.sv -----
// ----------------------------------------------------------------------------
// bqc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bqc_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/bqc_lex.sv -----
// ----------------------------------------------------------------------------
// bqc_lex: lexical mode step and bracket decision
// Computes the next mode, the stack operation and any result for one beat.
// ----------------------------------------------------------------------------
module bqc_lex #(
   parameter int STACK_DEPTH = bqc_pkg::BQC_STACK_DEPTH
) (
   input  bqc_pkg::req_type                  req,
   input  logic [bqc_pkg::MODE_W-1:0]        mode,
   input  logic [$clog2(STACK_DEPTH+1)-1:0]  depth,
   input  logic [bqc_pkg::KIND_W-1:0]        top_kind,
   output logic [bqc_pkg::MODE_W-1:0]        mode_next,
   output bqc_pkg::stack_op_type             op,
   output logic                              emit,
   output bqc_pkg::rsp_type                  rsp
);
   import bqc_pkg::*;

   localparam int DEPTH_W = $clog2(STACK_DEPTH+1);

   logic [7:0]        ch;
   logic              empty;
   logic              full;
   logic              run_normal;
   logic [MODE_W-1:0] lex_mode;
   logic [MODE_W-1:0] norm_mode;
   logic [3:0]        norm_status;
   logic              norm_push;
   logic              norm_pop;
   logic [KIND_W-1:0] norm_kind;

   assign ch    = req.text_byte;
   assign empty = (depth == '0);
   assign full  = (depth == DEPTH_W'(STACK_DEPTH));

   // Normal-code handling of one byte
   always_comb begin
      norm_mode   = MODE_NORMAL;
      norm_status = ST_OK;
      norm_push   = 1'b0;
      norm_pop    = 1'b0;
      norm_kind   = KIND_PAREN;
      case (ch)
         CH_DQUOTE: norm_mode = MODE_DQ;
         CH_SQUOTE: norm_mode = MODE_SQ;
         CH_SLASH:  norm_mode = MODE_SLASH;
         CH_LPAREN, CH_LBRACE, CH_LSQUARE: begin
            norm_kind = (ch == CH_LPAREN) ? KIND_PAREN :
                        (ch == CH_LBRACE) ? KIND_BRACE : KIND_SQUARE;
            if (full) begin
               norm_status = ST_OVERFLOW;
            end else begin
               norm_push = 1'b1;
            end
         end
         CH_RPAREN, CH_RBRACE, CH_RSQUARE: begin
            norm_kind = (ch == CH_RPAREN) ? KIND_PAREN :
                        (ch == CH_RBRACE) ? KIND_BRACE : KIND_SQUARE;
            if (empty || top_kind != norm_kind) begin
               norm_status = (ch == CH_RPAREN) ? ST_BAD_PAREN :
                             (ch == CH_RBRACE) ? ST_BAD_BRACE : ST_BAD_SQUARE;
            end else begin
               norm_pop = 1'b1;
            end
         end
         default: norm_mode = MODE_NORMAL;
      endcase
   end

   // Mode transitions outside normal code
   always_comb begin
      lex_mode   = mode;
      run_normal = 1'b0;
      case (mode)
         MODE_NORMAL: run_normal = 1'b1;
         MODE_SLASH: begin
            if (ch == CH_SLASH) begin
               lex_mode = MODE_LINE;
            end else if (ch == CH_STAR) begin
               lex_mode = MODE_BLOCK;
            end else begin
               run_normal = 1'b1;
            end
         end
         MODE_DQ: begin
            if (ch == CH_BSLASH) begin
               lex_mode = MODE_DQ_ESC;
            end else if (ch == CH_DQUOTE) begin
               lex_mode = MODE_NORMAL;
            end
         end
         MODE_DQ_ESC: lex_mode = MODE_DQ;
         MODE_SQ: begin
            if (ch == CH_BSLASH) begin
               lex_mode = MODE_SQ_ESC;
            end else if (ch == CH_SQUOTE) begin
               lex_mode = MODE_NORMAL;
            end
         end
         MODE_SQ_ESC: lex_mode = MODE_SQ;
         MODE_LINE: begin
            if (ch == CH_NEWLINE) begin
               lex_mode = MODE_NORMAL;
            end
         end
         MODE_BLOCK: begin
            if (ch == CH_STAR) begin
               lex_mode = MODE_BLOCK_STAR;
            end
         end
         MODE_BLOCK_STAR: begin
            if (ch == CH_SLASH) begin
               lex_mode = MODE_NORMAL;
            end else if (ch != CH_STAR) begin
               lex_mode = MODE_BLOCK;
            end
         end
         default: lex_mode = MODE_HALTED;
      endcase
   end

   // Combine into the beat decision
   always_comb begin
      mode_next     = lex_mode;
      op.push       = 1'b0;
      op.pop        = 1'b0;
      op.kind       = norm_kind;
      emit          = 1'b0;
      rsp.status    = ST_OK;
      rsp.open_left = 1'b0;
      if (req.end_of_text) begin
         // Close out the text and return to the reset mode
         mode_next     = MODE_NORMAL;
         emit          = (mode != MODE_HALTED);
         rsp.open_left = !empty;
         case (mode)
            MODE_DQ_ESC:                rsp.status = ST_DQ_ESC_END;
            MODE_DQ:                    rsp.status = ST_DQ_OPEN;
            MODE_SQ_ESC:                rsp.status = ST_SQ_ESC_END;
            MODE_SQ:                    rsp.status = ST_SQ_OPEN;
            MODE_BLOCK, MODE_BLOCK_STAR: rsp.status = ST_BLOCK_OPEN;
            default:                    rsp.status = empty ? ST_OK : ST_OPEN_REMAIN;
         endcase
      end else if (run_normal) begin
         if (norm_status != ST_OK) begin
            // First error: report and halt until end of text
            mode_next  = MODE_HALTED;
            emit       = 1'b1;
            rsp.status = norm_status;
         end else begin
            mode_next = norm_mode;
            op.push   = norm_push;
            op.pop    = norm_pop;
         end
      end
   end

endmodule

// ----- sv/c_bracket_quote_checker_core.sv -----
// ----------------------------------------------------------------------------
// c_bracket_quote_checker_core: bracket and quote checker for C source text
// Tracks lexical mode and keeps the bracket stack in a RAM with a cached top.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle while the output register is free or draining.
// Output: a result beat appears on rsp_ in the cycle after the causing req_ beat.
// The RAM read port always prefetches the entry below the top of stack, so a
// pop in the next cycle finds its new top ready.
// Reset: mode returns to normal code and the stack to empty; RAM is not cleared.
// ----------------------------------------------------------------------------
module c_bracket_quote_checker_core #(
   parameter int STACK_DEPTH = bqc_pkg::BQC_STACK_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bqc_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bqc_pkg::rsp_type rsp_payload
);
   import bqc_pkg::*;

   localparam int DEPTH_W = $clog2(STACK_DEPTH+1);
   localparam int ADDR_W  = $clog2(STACK_DEPTH);

   logic [MODE_W-1:0]  mode_ff;
   logic [MODE_W-1:0]  mode_in;
   logic [DEPTH_W-1:0] depth_ff;
   logic [DEPTH_W-1:0] depth_in;
   logic [KIND_W-1:0]  top_ff;
   logic [KIND_W-1:0]  top_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;

   logic [MODE_W-1:0]  lex_mode_next;
   stack_op_type       lex_op;
   logic               lex_emit;
   rsp_type            lex_rsp;
   logic [KIND_W-1:0]  below_kind;
   logic               accept;
   logic [DEPTH_W-1:0] rd_depth;

   // Accept while the output register is free or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   bqc_lex #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_lex (
      .req       (req_payload),
      .mode      (mode_ff),
      .depth     (depth_ff),
      .top_kind  (top_ff),
      .mode_next (lex_mode_next),
      .op        (lex_op),
      .emit      (lex_emit),
      .rsp       (lex_rsp)
   );

   // Next stack and mode state
   always_comb begin
      mode_in  = mode_ff;
      depth_in = depth_ff;
      top_in   = top_ff;
      if (accept) begin
         mode_in = lex_mode_next;
         if (req_payload.end_of_text) begin
            depth_in = '0;
         end else if (lex_op.push) begin
            depth_in = depth_ff + DEPTH_W'(1);
            top_in   = lex_op.kind;
         end else if (lex_op.pop) begin
            depth_in = depth_ff - DEPTH_W'(1);
            top_in   = below_kind;
         end
      end
   end

   // Prefetch the entry under the next top of stack
   assign rd_depth = depth_in - DEPTH_W'(2);

   bqc_ram #(
      .WIDTH (KIND_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (accept && lex_op.push),
      .wr_addr (depth_ff[ADDR_W-1:0]),
      .wr_data (lex_op.kind),
      .rd_addr (rd_depth[ADDR_W-1:0]),
      .rd_data (below_kind)
   );

   // Output register: load a new result or drop the taken one
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (accept && lex_emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = lex_rsp;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_NORMAL;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload state
   always_ff @(posedge clock) begin
      top_ff <= top_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ----- tb/c_bracket_quote_checker_core_tb.sv -----
// ----------------------------------------------------------------------------
// c_bracket_quote_checker_core_tb: self-checking bench for the bracket checker
// Feeds C text beats through a short directed table, one full-stack text
// and many random texts, and compares every result beat with a typed-in result
// or a predictor that tracks lexical mode and bracket nesting on its own.
// ----------------------------------------------------------------------------
module c_bracket_quote_checker_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bqc_pkg::*;

   localparam int STACK_DEPTH  = BQC_STACK_DEPTH;
   localparam int RANDOM_BEATS = 250;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int IDLE_PCT     = 21;
   localparam int NUM_ROWS     = 26;

   // One directed row: the beat, and the result typed in where it is obvious
   typedef struct packed {
      req_type beat;
      bit      typed;
      rsp_type want;
   } dir_row_type;

   localparam rsp_type BY_MODEL = '0;

   localparam dir_row_type DIRECTED_ROWS [0:NUM_ROWS-1] = '{
      // empty text right after reset
      '{'{8'h00, 1'b1}, 1'b1, '{ST_OK, 1'b0}},
      // byte extremes in code, then open bracket left at end
      '{'{CH_LPAREN, 1'b0}, 1'b0, BY_MODEL},
      '{'{8'h00, 1'b0}, 1'b0, BY_MODEL},
      '{'{8'hFF, 1'b1}, 1'b1, '{ST_OPEN_REMAIN, 1'b1}},
      // close on empty stack, then ignored bytes and a silent end
      '{'{CH_RPAREN, 1'b0}, 1'b1, '{ST_BAD_PAREN, 1'b0}},
      '{'{CH_LBRACE, 1'b0}, 1'b0, BY_MODEL},
      '{'{8'h00, 1'b1}, 1'b0, BY_MODEL},
      // end inside an escape in double quotes
      '{'{CH_DQUOTE, 1'b0}, 1'b0, BY_MODEL},
      '{'{8'hFF, 1'b0}, 1'b0, BY_MODEL},
      '{'{CH_BSLASH, 1'b0}, 1'b0, BY_MODEL},
      '{'{8'h00, 1'b1}, 1'b1, '{ST_DQ_ESC_END, 1'b0}},
      // open single quote wins over open brackets
      '{'{CH_LBRACE, 1'b0}, 1'b0, BY_MODEL},
      '{'{CH_SQUOTE, 1'b0}, 1'b0, BY_MODEL},
      '{'{8'h00, 1'b1}, 1'b1, '{ST_SQ_OPEN, 1'b1}},
      // open block comment
      '{'{CH_SLASH, 1'b0}, 1'b0, BY_MODEL},
      '{'{CH_STAR, 1'b0}, 1'b0, BY_MODEL},
      '{'{8'h00, 1'b1}, 1'b1, '{ST_BLOCK_OPEN, 1'b0}},
      // lone slash: the next byte is still code
      '{'{CH_SLASH, 1'b0}, 1'b0, BY_MODEL},
      '{'{CH_RSQUARE, 1'b0}, 1'b1, '{ST_BAD_SQUARE, 1'b0}},
      '{'{8'h00, 1'b1}, 1'b0, BY_MODEL},
      // line comment running into end of text
      '{'{CH_SLASH, 1'b0}, 1'b0, BY_MODEL},
      '{'{CH_SLASH, 1'b0}, 1'b0, BY_MODEL},
      '{'{8'h00, 1'b1}, 1'b1, '{ST_OK, 1'b0}},
      // slash pending at end of text
      '{'{CH_LSQUARE, 1'b0}, 1'b0, BY_MODEL},
      '{'{CH_SLASH, 1'b0}, 1'b0, BY_MODEL},
      '{'{8'h00, 1'b1}, 1'b1, '{ST_OPEN_REMAIN, 1'b1}}
   };

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   // Predictor state
   logic [MODE_W-1:0] lex_now = MODE_NORMAL;
   logic [KIND_W-1:0] nest_kinds [STACK_DEPTH];
   int                nest_depth = 0;

   rsp_type expected_status [$];
   int      err_count   = 0;
   int      cycle_count = 0;
   int      live_beats  = 0;
   bit      calm        = 1'b0;

   c_bracket_quote_checker_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #1 clock = ~clock;

   // Guard against a hang
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic logic [7:0] open_char(logic [KIND_W-1:0] k);
      case (k)
         KIND_PAREN: return CH_LPAREN;
         KIND_BRACE: return CH_LBRACE;
         default:    return CH_LSQUARE;
      endcase
   endfunction

   function automatic logic [7:0] close_char(logic [KIND_W-1:0] k);
      case (k)
         KIND_PAREN: return CH_RPAREN;
         KIND_BRACE: return CH_RBRACE;
         default:    return CH_RSQUARE;
      endcase
   endfunction

   // Apply one byte seen in code mode; return an error status or ST_OK
   task automatic code_byte(input logic [7:0] c, output logic [3:0] st);
      logic [KIND_W-1:0] k;
      st = ST_OK;
      k = (c == CH_LPAREN || c == CH_RPAREN) ? KIND_PAREN :
          (c == CH_LBRACE || c == CH_RBRACE) ? KIND_BRACE : KIND_SQUARE;
      case (c)
         CH_DQUOTE: lex_now = MODE_DQ;
         CH_SQUOTE: lex_now = MODE_SQ;
         CH_SLASH:  lex_now = MODE_SLASH;
         CH_LPAREN, CH_LBRACE, CH_LSQUARE: begin
            if (nest_depth >= STACK_DEPTH) begin
               st = ST_OVERFLOW;
            end else begin
               nest_kinds[nest_depth] = k;
               nest_depth++;
            end
         end
         CH_RPAREN, CH_RBRACE, CH_RSQUARE: begin
            if (nest_depth == 0 || nest_kinds[nest_depth-1] != k) begin
               st = (k == KIND_PAREN) ? ST_BAD_PAREN :
                    (k == KIND_BRACE) ? ST_BAD_BRACE : ST_BAD_SQUARE;
            end else begin
               nest_depth--;
            end
         end
         default: ;
      endcase
   endtask

   // Advance the predictor by one accepted beat
   task automatic check_text_beat(input req_type beat, output bit has,
                                  output rsp_type res);
      logic [3:0] st;
      logic       open;
      has = 1'b0;
      res = '0;
      st  = ST_OK;
      if (beat.end_of_text) begin
         open = (nest_depth > 0);
         has  = (lex_now != MODE_HALTED);
         case (lex_now)
            MODE_DQ_ESC:                st = ST_DQ_ESC_END;
            MODE_DQ:                    st = ST_DQ_OPEN;
            MODE_SQ_ESC:                st = ST_SQ_ESC_END;
            MODE_SQ:                    st = ST_SQ_OPEN;
            MODE_BLOCK, MODE_BLOCK_STAR: st = ST_BLOCK_OPEN;
            default:                    st = open ? ST_OPEN_REMAIN : ST_OK;
         endcase
         res.status    = st;
         res.open_left = open;
         lex_now    = MODE_NORMAL;
         nest_depth = 0;
      end else begin
         case (lex_now)
            MODE_NORMAL: code_byte(beat.text_byte, st);
            MODE_SLASH: begin
               if (beat.text_byte == CH_SLASH) begin
                  lex_now = MODE_LINE;
               end else if (beat.text_byte == CH_STAR) begin
                  lex_now = MODE_BLOCK;
               end else begin
                  lex_now = MODE_NORMAL;
                  code_byte(beat.text_byte, st);
               end
            end
            MODE_DQ: begin
               if (beat.text_byte == CH_BSLASH) lex_now = MODE_DQ_ESC;
               else if (beat.text_byte == CH_DQUOTE) lex_now = MODE_NORMAL;
            end
            MODE_DQ_ESC: lex_now = MODE_DQ;
            MODE_SQ: begin
               if (beat.text_byte == CH_BSLASH) lex_now = MODE_SQ_ESC;
               else if (beat.text_byte == CH_SQUOTE) lex_now = MODE_NORMAL;
            end
            MODE_SQ_ESC: lex_now = MODE_SQ;
            MODE_LINE: begin
               if (beat.text_byte == CH_NEWLINE) lex_now = MODE_NORMAL;
            end
            MODE_BLOCK: begin
               if (beat.text_byte == CH_STAR) lex_now = MODE_BLOCK_STAR;
            end
            MODE_BLOCK_STAR: begin
               if (beat.text_byte == CH_SLASH) lex_now = MODE_NORMAL;
               else if (beat.text_byte != CH_STAR) lex_now = MODE_BLOCK;
            end
            default: lex_now = MODE_HALTED;
         endcase
         if (st != ST_OK) begin
            lex_now       = MODE_HALTED;
            has           = 1'b1;
            res.status    = st;
            res.open_left = 1'b0;
         end
      end
   endtask

   // Drive one beat from a falling edge until it is accepted; return at a falling edge
   task automatic send_beat(input req_type beat, input bit typed, input rsp_type want);
      bit      has;
      rsp_type res;
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (!(lex_now == MODE_HALTED && !beat.end_of_text)) live_beats++;
      check_text_beat(beat, has, res);
      if (typed) expected_status.push_back(want);
      else if (has) expected_status.push_back(res);
      @(negedge clock);
   endtask

   task automatic put_byte(input logic [7:0] c);
      send_beat('{c, 1'b0}, 1'b0, BY_MODEL);
   endtask

   task automatic put_end();
      send_beat('{8'($urandom_range(0, 255)), 1'b1}, 1'b0, BY_MODEL);
   endtask

   // Quoted text with random content; quote and backslash are escaped
   task automatic put_quoted(input logic [7:0] q, input bit closed);
      logic [7:0] c;
      put_byte(q);
      repeat ($urandom_range(0, 6)) begin
         c = 8'($urandom_range(0, 255));
         if (c == q || c == CH_BSLASH) put_byte(CH_BSLASH);
         put_byte(c);
      end
      if (closed) put_byte(q);
   endtask

   task automatic put_line_comment(input bit closed);
      logic [7:0] c;
      put_byte(CH_SLASH);
      put_byte(CH_SLASH);
      repeat ($urandom_range(0, 6)) begin
         c = 8'($urandom_range(0, 255));
         put_byte(c == CH_NEWLINE ? 8'h20 : c);
      end
      if (closed) put_byte(CH_NEWLINE);
   endtask

   // Block comment with star runs inside; never closes early
   task automatic put_block_comment(input bit closed);
      logic [7:0] c;
      logic [7:0] prev;
      prev = 8'h00;
      put_byte(CH_SLASH);
      put_byte(CH_STAR);
      repeat ($urandom_range(0, 8)) begin
         c = ($urandom_range(0, 3) == 0) ? CH_STAR : 8'($urandom_range(0, 255));
         if (prev == CH_STAR && c == CH_SLASH) c = 8'h20;
         put_byte(c);
         prev = c;
      end
      if (closed) begin
         repeat ($urandom_range(1, 3)) put_byte(CH_STAR);
         put_byte(CH_SLASH);
      end
   endtask

   // Fill the stack to the top, then close it, spill over, or leave it open
   task automatic deep_text(input int variant);
      logic [KIND_W-1:0] kinds [$];
      logic [KIND_W-1:0] k;
      repeat (STACK_DEPTH) begin
         k = KIND_W'($urandom_range(0, 2));
         kinds.push_back(k);
         put_byte(open_char(k));
      end
      if (variant == 0) begin
         while (kinds.size() > 0) put_byte(close_char(kinds.pop_back()));
      end else if (variant == 1) begin
         put_byte(open_char(KIND_W'($urandom_range(0, 2))));
         repeat (3) put_byte(8'($urandom_range(0, 255)));
      end
      put_end();
   endtask

   // One random text: mostly well formed, with noise and broken pieces
   task automatic random_text();
      logic [KIND_W-1:0] opened [$];
      logic [KIND_W-1:0] k;
      int                pick;
      repeat ($urandom_range(1, 14)) begin
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            k = KIND_W'($urandom_range(0, 2));
            opened.push_back(k);
            put_byte(open_char(k));
         end else if (pick < 38) begin
            if (opened.size() > 0 && $urandom_range(0, 9) != 0)
               put_byte(close_char(opened.pop_back()));
            else
               put_byte(close_char(KIND_W'($urandom_range(0, 2))));
         end else if (pick < 48) begin
            put_quoted(CH_DQUOTE, 1'b1);
         end else if (pick < 56) begin
            put_quoted(CH_SQUOTE, 1'b1);
         end else if (pick < 62) begin
            put_line_comment(1'b1);
         end else if (pick < 70) begin
            put_block_comment(1'b1);
         end else if (pick < 76) begin
            put_byte(CH_SLASH);
            if (opened.size() > 0 && $urandom_range(0, 1) == 1)
               put_byte(close_char(opened.pop_back()));
            else
               put_byte(8'($urandom_range(0, 255)));
         end else if (pick < 92) begin
            put_byte(8'($urandom_range(0, 255)));
         end else begin
            while (opened.size() > 0) put_byte(close_char(opened.pop_back()));
         end
      end
      // close up most texts, leave some open or cut off mid-token
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
         while (opened.size() > 0) put_byte(close_char(opened.pop_back()));
      end
      if (pick >= 82) begin
         case ($urandom_range(0, 6))
            0: put_quoted(CH_DQUOTE, 1'b0);
            1: put_quoted(CH_SQUOTE, 1'b0);
            2: begin put_byte(CH_DQUOTE); put_byte(CH_BSLASH); end
            3: begin put_byte(CH_SQUOTE); put_byte(CH_BSLASH); end
            4: put_block_comment(1'b0);
            5: put_line_comment(1'b0);
            default: put_byte(CH_SLASH);
         endcase
      end
      put_end();
   endtask

   // Hold the result side ready or stalled at random
   always @(negedge clock) begin
      rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   task automatic flag_result(input string what, input rsp_type want, input rsp_type got);
      err_count++;
      if (err_count <= 10)
         $display("%0t: %s: expected status %0d open_left %0b, got status %0d open_left %0b",
                  $realtime, what, want.status, want.open_left, got.status, got.open_left);
   endtask

   // Compare each result beat with the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_status.size() == 0) begin
            flag_result("unexpected result", '0, rsp_payload);
         end else begin
            want = expected_status.pop_front();
            if (rsp_payload.status !== want.status ||
                rsp_payload.open_left !== want.open_left)
               flag_result("result mismatch", want, rsp_payload);
         end
      end
   end

   initial begin
      int first_random;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // walk the directed table
      for (int i = 0; i < NUM_ROWS; i++)
         send_beat(DIRECTED_ROWS[i].beat, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

      // full stack, then overflow
      deep_text(1);

      // random texts, with a stretch where neither side idles
      first_random = live_beats;
      while (live_beats - first_random < RANDOM_BEATS) begin
         calm = (live_beats - first_random >= 80) && (live_beats - first_random < 200);
         random_text();
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      // drain, then allow for stray beats
      while (expected_status.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/bqc_pkg.sv
sv/bqc_ram.sv
sv/bqc_lex.sv
sv/c_bracket_quote_checker_core.sv
tb/c_bracket_quote_checker_core_tb.sv
